@@ rtl/tlr_pkg.sv @@
// Package: shared types, constants and helpers for the tile line rasterizer.
`timescale 1ns / 1ps
package tlr_pkg;

  localparam int CoordBits     = 6;
  localparam int AccBits       = CoordBits + 1;
  localparam int TileBits      = 8;
  localparam int QueueDepth    = 2;
  localparam int QueuePtrBits  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntBits  = $clog2(QueueDepth + 1);

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [AccBits-1:0]   acc_t;
  typedef logic [TileBits-1:0]  tile_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_INC  = 2'b01,
    DIR_DEC  = 2'b10
  } dir_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } back_state_e;

  typedef struct packed {
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;
    tile_t  tile_code;
  } line_req_t;

  typedef struct packed {
    coord_t tile_x;
    coord_t tile_y;
    tile_t  tile_value;
    logic   last;
  } point_t;

  // Classified line, handed from front to back through the queue
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t major_span;
    coord_t minor_span;
    dir_e   step_x;
    dir_e   step_y;
    logic   x_is_major;
    tile_t  tile;
  } line_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic coord_t coord_move(coord_t v, dir_e d);
    coord_t r;
    r = v;
    case (d)
      DIR_INC: r = v + coord_t'(1);
      DIR_DEC: r = v - coord_t'(1);
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/tlr_req_if.sv @@
// Interfaces: line request channel and point result channel.
`timescale 1ns / 1ps
interface tlr_req_if;
  import tlr_pkg::*;
  logic      valid;
  logic      ready;
  line_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tlr_pt_if;
  import tlr_pkg::*;
  logic   valid;
  logic   ready;
  point_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tile_line_rasterizer.sv @@
// Top level: tile line rasterizer, front classifier, command queue and point stepper.
`timescale 1ns / 1ps
// A line request (from, to, tile code) on req_i produces max(|dx|, |dy|) + 1 points on
// pt_o, start point first, each carrying the tile code, with last set on the final point.
// The back stepper emits one point per cycle while pt_o is ready, so a line spans 1 to 64
// points at 6-bit coordinates. The first point reaches pt_o after the request passes the
// front register, the queue write and the stepper load. A two-entry command queue lets
// requests be taken while a line is still being drawn, and the next line's first point
// follows the previous line's last point with no gap when its command is already queued.
module tile_line_rasterizer (
  input  logic     clk_i,
  input  logic     rst_ni,
  tlr_req_if.sink  req_i,
  tlr_pt_if.source pt_o
);
  import tlr_pkg::*;

  line_cmd_t     f_cmd, q_cmd;
  logic          f_valid, f_ready, q_valid, q_ready;
  queue_status_t q_status;

  tlr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (f_cmd),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready)
  );

  tlr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cmd_i   (f_cmd),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .rd_cmd_o   (q_cmd),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .status_o   (q_status)
  );

  tlr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .pt_o        (pt_o)
  );

  // A line in progress keeps the output stream going
  a_stream_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_o.valid && pt_o.ready && !pt_o.data.last) |=> pt_o.valid)
    else $error("point stream dropped valid inside a line");

  // Tile code is constant across the points of one line
  a_tile_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_o.valid && pt_o.ready && !pt_o.data.last) |=> $stable(pt_o.data.tile_value))
    else $error("tile value changed inside a line");

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("command queue both full and empty");

  // Queue only pops when the stepper is free or finishing its last point
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready && pt_o.valid) |-> (pt_o.ready && pt_o.data.last))
    else $error("new line loaded before the current one finished");

endmodule

@@ rtl/tlr_front.sv @@
// Front stage: accepts line requests and classifies axis, spans and step directions.
`timescale 1ns / 1ps
module tlr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tlr_req_if.sink           req_i,
  output tlr_pkg::line_cmd_t cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i
);
  import tlr_pkg::*;

  coord_t    dx, dy;
  dir_e      sx, sy;
  logic      x_major;
  line_cmd_t cmd_d, cmd_q;
  logic      valid_q;
  logic      req_fire;

  always_comb begin
    dx = (req_i.data.from_x > req_i.data.to_x) ? req_i.data.from_x - req_i.data.to_x
                                               : req_i.data.to_x - req_i.data.from_x;
    dy = (req_i.data.from_y > req_i.data.to_y) ? req_i.data.from_y - req_i.data.to_y
                                               : req_i.data.to_y - req_i.data.from_y;
    if (req_i.data.from_x < req_i.data.to_x) begin
      sx = DIR_INC;
    end else if (req_i.data.from_x > req_i.data.to_x) begin
      sx = DIR_DEC;
    end else begin
      sx = DIR_NONE;
    end
    if (req_i.data.from_y < req_i.data.to_y) begin
      sy = DIR_INC;
    end else if (req_i.data.from_y > req_i.data.to_y) begin
      sy = DIR_DEC;
    end else begin
      sy = DIR_NONE;
    end
    // tie goes to x
    x_major          = (dx >= dy);
    cmd_d.start_x    = req_i.data.from_x;
    cmd_d.start_y    = req_i.data.from_y;
    cmd_d.major_span = x_major ? dx : dy;
    cmd_d.minor_span = x_major ? dy : dx;
    cmd_d.step_x     = sx;
    cmd_d.step_y     = sy;
    cmd_d.x_is_major = x_major;
    cmd_d.tile       = req_i.data.tile_code;
  end

  assign req_i.ready = !valid_q || cmd_ready_i;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_fire) begin
      valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

@@ rtl/tlr_queue.sv @@
// Short command queue between the front and back stages.
`timescale 1ns / 1ps
module tlr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlr_pkg::line_cmd_t    wr_cmd_i,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  output tlr_pkg::line_cmd_t    rd_cmd_o,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output tlr_pkg::queue_status_t status_o
);
  import tlr_pkg::*;

  line_cmd_t                entry_q [QueueDepth];
  logic [QueuePtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntBits-1:0]  count_q;
  logic                     push, pop;

  assign status_o.full  = (count_q == QueueCntBits'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign wr_ready_o     = !status_o.full;
  assign rd_valid_o     = !status_o.empty;
  assign rd_cmd_o       = entry_q[rd_ptr_q];
  assign push           = wr_valid_i && wr_ready_o;
  assign pop            = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0
                                                                : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0
                                                                : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

@@ rtl/tlr_back.sv @@
// Back stage: steps through a classified line, one registered point per cycle while pt_o is ready.
`timescale 1ns / 1ps
module tlr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlr_pkg::line_cmd_t cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  tlr_pt_if.source           pt_o
);
  import tlr_pkg::*;

  back_state_e state_q, state_d;
  coord_t      cur_x_q, cur_y_q, remain_q, major_q, minor_q;
  acc_t        accum_q;
  dir_e        step_x_q, step_y_q;
  logic        x_major_q;
  tile_t       tile_q;

  logic        last_pt, pt_fire, load;
  acc_t        sum, accum_d;
  logic        minor_step;
  coord_t      nx_x, nx_y;

  assign last_pt = (remain_q == '0);
  assign pt_fire = pt_o.valid && pt_o.ready;
  assign load    = cmd_valid_i && cmd_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_valid_i) state_d = ST_RUN;
      ST_RUN:  if (pt_fire && last_pt && !cmd_valid_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    case (state_q)
      ST_IDLE: begin
        pt_o.valid  = 1'b0;
        cmd_ready_o = 1'b1;
      end
      ST_RUN: begin
        pt_o.valid  = 1'b1;
        cmd_ready_o = pt_o.ready && last_pt;
      end
      default: begin
        pt_o.valid  = 1'b0;
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  assign pt_o.data.tile_x     = cur_x_q;
  assign pt_o.data.tile_y     = cur_y_q;
  assign pt_o.data.tile_value = tile_q;
  assign pt_o.data.last       = last_pt;

  // Error term stays below major span, so the sum never wraps
  always_comb begin
    sum        = accum_q + acc_t'(minor_q);
    minor_step = (sum >= acc_t'(major_q));
    accum_d    = minor_step ? sum - acc_t'(major_q) : sum;
    nx_x       = (x_major_q || minor_step) ? coord_move(cur_x_q, step_x_q) : cur_x_q;
    nx_y       = (!x_major_q || minor_step) ? coord_move(cur_y_q, step_y_q) : cur_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_x_q   <= cmd_i.start_x;
      cur_y_q   <= cmd_i.start_y;
      remain_q  <= cmd_i.major_span;
      major_q   <= cmd_i.major_span;
      minor_q   <= cmd_i.minor_span;
      step_x_q  <= cmd_i.step_x;
      step_y_q  <= cmd_i.step_y;
      x_major_q <= cmd_i.x_is_major;
      tile_q    <= cmd_i.tile;
      accum_q   <= '0;
    end else if (pt_fire && !last_pt) begin
      cur_x_q  <= nx_x;
      cur_y_q  <= nx_y;
      accum_q  <= accum_d;
      remain_q <= remain_q - 1'b1;
    end
  end

endmodule
